[src/sma_pkg.sv]
`default_nettype none

package sma_pkg;

    // Default geometry
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int STACK_DEPTH_DEF = 1024;

    localparam int FUNC_W = 4;
    localparam int FLAG_W = 3;

    // Instruction codes
    typedef enum logic [FUNC_W-1:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MAX   = 4'd5,
        OP_MIN   = 4'd6,
        OP_NEG   = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_PUSH1,
        ST_PUSH2,
        ST_DONE
    } state_t;

    // Request to the iterative multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

`default_nettype wire

[src/sma_stack_ram.sv]
`default_nettype none

module sma_stack_ram
    import sma_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  wire                   aclk,
    input  wire                   wr_en,
    input  wire  [ADDR_W-1:0]     wr_addr,
    input  wire  [DATA_WIDTH-1:0] wr_data,
    input  wire                   rd_en,
    input  wire  [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/sma_muldiv.sv]
`default_nettype none

module sma_muldiv
    import sma_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire  md_req_t         req,
    input  wire  [DATA_WIDTH-1:0] op_a,
    input  wire  [DATA_WIDTH-1:0] op_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  is_div_reg;
    logic                  neg_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH-1:0] acc_reg;   // product sum or partial remainder
    logic [DATA_WIDTH-1:0] x_reg;     // multiplicand or dividend/quotient
    logic [DATA_WIDTH-1:0] y_reg;     // multiplier or divisor

    logic [DATA_WIDTH-1:0] abs_a;
    logic [DATA_WIDTH-1:0] abs_b;
    logic [DATA_WIDTH-1:0] rem_sh;
    logic [DATA_WIDTH:0]   diff;

    // Operand magnitudes for the divide
    assign abs_a = op_a[DATA_WIDTH-1] ? ('0 - op_a) : op_a;
    assign abs_b = op_b[DATA_WIDTH-1] ? ('0 - op_b) : op_b;

    // One restoring step: the remainder stays below the divisor magnitude
    assign rem_sh = {acc_reg[DATA_WIDTH-2:0], x_reg[DATA_WIDTH-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, y_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: one bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            is_div_reg <= req.is_div;
            neg_reg    <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
            cnt_reg    <= CW'(DATA_WIDTH - 1);
            acc_reg    <= '0;
            x_reg      <= req.is_div ? abs_a : op_a;
            y_reg      <= req.is_div ? abs_b : op_b;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (is_div_reg) begin
                if (!diff[DATA_WIDTH]) begin
                    acc_reg <= diff[DATA_WIDTH-1:0];
                    x_reg   <= {x_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    acc_reg <= rem_sh;
                    x_reg   <= {x_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                if (y_reg[0]) begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[DATA_WIDTH-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[DATA_WIDTH-1:1]};
            end
        end
    end

    // Signed quotient fix-up or wrapped product
    assign done   = done_reg;
    assign result = is_div_reg ? (neg_reg ? ('0 - x_reg) : x_reg) : acc_reg;

endmodule

`default_nettype wire

[src/stack_machine_alu.sv]
// Integer stack machine for reverse Polish evaluation. Each s_axis beat
// carries one instruction (tuser) and an immediate (tdata, used by CONST);
// each m_axis beat reports the new top of stack, the new depth and the
// underflow, overflow and divide-by-zero flags. The stack lives in a
// single-port-write, registered-read RAM of STACK_DEPTH words; the top
// entry is also cached in a register, so an instruction reads only the
// second entry from RAM. Items are processed one at a time: an instruction
// is accepted (with its RAM read), executed, pushed and loaded into the
// output register; unused codes skip the push since they push nothing,
// DUP and SWAP push twice since they write two entries through the one RAM
// write port, and MUL and DIV with a nonzero divisor also wait on the
// bit-serial multiply/divide unit. A stalled m_axis delays the output
// load. A new instruction is accepted while the previous result waits on
// m_axis.
// The stack RAM needs no clearing after reset: only entries below the
// current depth are ever used, and each of those was written by a push.
`default_nettype none

module stack_machine_alu
    import sma_pkg::*;
#(
    parameter int   DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int   STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int  CNT_W       = $clog2(STACK_DEPTH + 1),
    localparam int  ADDR_W      = $clog2(STACK_DEPTH),
    localparam int  IN_W        = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int  OUT_W       = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [IN_W-1:0]    s_axis_tdata,   // imm_value
    input  wire  [FUNC_W-1:0]  s_axis_tuser,   // func

    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // top_value, stack_count
    output logic [FLAG_W-1:0]  m_axis_tuser    // underflow, overflow, div_by_zero
);

    state_t                state_reg;
    state_t                state_next;

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] imm_reg;
    logic [CNT_W-1:0]      depth_reg;
    logic [DATA_WIDTH-1:0] top_reg;
    logic [DATA_WIDTH-1:0] v1_reg;
    logic [DATA_WIDTH-1:0] v2_reg;
    logic                  uf_reg;
    logic                  of_reg;
    logic                  dz_reg;

    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] m_top_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic [FLAG_W-1:0]     m_flags_reg;

    logic                  accept;
    logic                  out_load;
    logic                  room;

    logic                  ram_wr_en;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [CNT_W-1:0]      rd_ptr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    md_req_t               md_req;
    logic                  md_done;
    logic [DATA_WIDTH-1:0] md_result;

    logic [1:0]            n_pop;
    logic [1:0]            n_push;
    logic                  pop_under;
    logic [CNT_W-1:0]      base;
    logic [DATA_WIDTH-1:0] a_val;
    logic [DATA_WIDTH-1:0] b_val;
    logic [DATA_WIDTH-1:0] alu_v1;
    logic [DATA_WIDTH-1:0] alu_v2;
    logic                  div_zero;
    logic                  use_md;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign room     = depth_reg < CNT_W'(STACK_DEPTH);
    assign rd_ptr   = depth_reg - CNT_W'(2);

    // Stack storage
    sma_stack_ram #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (depth_reg[ADDR_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Multiply and divide
    sma_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (a_val),
        .op_b    (b_val),
        .done    (md_done),
        .result  (md_result)
    );

    // Pop operands: a from the cached top, b from the RAM read issued at accept
    assign a_val = (depth_reg != '0) ? top_reg : '0;
    assign b_val = (depth_reg >= CNT_W'(2)) ? ram_rd_data : '0;

    // Decode pops, pushes and the combinational results
    always_comb begin
        n_pop    = 2'd0;
        n_push   = 2'd0;
        alu_v1   = a_val;
        alu_v2   = a_val;
        div_zero = 1'b0;
        use_md   = 1'b0;
        case (op_reg)
            OP_CONST: begin
                n_push = 2'd1;
                alu_v1 = imm_reg;
            end
            OP_ADD: begin
                n_pop  = 2'd2;
                n_push = 2'd1;
                alu_v1 = a_val + b_val;
            end
            OP_SUB: begin
                n_pop  = 2'd2;
                n_push = 2'd1;
                alu_v1 = a_val - b_val;
            end
            OP_MUL: begin
                n_pop  = 2'd2;
                n_push = 2'd1;
                use_md = 1'b1;
            end
            OP_DIV: begin
                n_pop    = 2'd2;
                n_push   = 2'd1;
                div_zero = (b_val == '0);
                use_md   = (b_val != '0);
                alu_v1   = '0;
            end
            OP_MAX: begin
                n_pop  = 2'd2;
                n_push = 2'd1;
                alu_v1 = ($signed(a_val) > $signed(b_val)) ? a_val : b_val;
            end
            OP_MIN: begin
                n_pop  = 2'd2;
                n_push = 2'd1;
                alu_v1 = ($signed(b_val) > $signed(a_val)) ? a_val : b_val;
            end
            OP_NEG: begin
                n_pop  = 2'd1;
                n_push = 2'd1;
                alu_v1 = '0 - a_val;
            end
            OP_DUP: begin
                n_pop  = 2'd1;
                n_push = 2'd2;
            end
            OP_SWAP: begin
                n_pop  = 2'd2;
                n_push = 2'd2;
                alu_v2 = b_val;
            end
            default: begin
                n_pop  = 2'd0;
                n_push = 2'd0;
            end
        endcase
    end

    // Depth after the pops; popping past empty leaves zero
    assign pop_under = CNT_W'(n_pop) > depth_reg;
    assign base      = pop_under ? '0 : (depth_reg - CNT_W'(n_pop));

    // Next state and control strobes
    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_data   = v1_reg;
        md_req.start  = 1'b0;
        md_req.is_div = (op_reg == OP_DIV);
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_rd_en     = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (use_md) begin
                    md_req.start = 1'b1;
                    state_next   = ST_WAIT;
                end else if (n_push != 2'd0) begin
                    state_next = ST_PUSH1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WAIT: begin
                if (md_done) begin
                    state_next = ST_PUSH1;
                end
            end
            ST_PUSH1: begin
                ram_wr_en  = room;
                state_next = (n_push == 2'd2) ? ST_PUSH2 : ST_DONE;
            end
            ST_PUSH2: begin
                ram_wr_en   = room;
                ram_wr_data = v2_reg;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Stack pointer and cached top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (state_reg == ST_EXEC) begin
            depth_reg <= base;
        end else if (ram_wr_en) begin
            depth_reg <= depth_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_wr_en) begin
            top_reg <= ram_wr_data;
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_axis_tuser);
            imm_reg <= s_axis_tdata[DATA_WIDTH-1:0];
            of_reg  <= 1'b0;
        end
        if (state_reg == ST_EXEC) begin
            v1_reg <= alu_v1;
            v2_reg <= alu_v2;
            uf_reg <= pop_under;
            dz_reg <= div_zero;
        end
        if (state_reg == ST_WAIT && md_done) begin
            v1_reg <= md_result;
        end
        if ((state_reg == ST_PUSH1 || state_reg == ST_PUSH2) && !room) begin
            of_reg <= 1'b1;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_top_reg   <= (depth_reg != '0) ? top_reg : '0;
            m_count_reg <= depth_reg;
            m_flags_reg <= {dz_reg, of_reg, uf_reg};
        end
    end

    // Pack the result beat
    always_comb begin
        m_axis_tdata                            = '0;
        m_axis_tdata[DATA_WIDTH-1:0]            = m_top_reg;
        m_axis_tdata[DATA_WIDTH+CNT_W-1:DATA_WIDTH] = m_count_reg;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_flags_reg;

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import sma_pkg::*;

    localparam int DW    = DATA_WIDTH_DEF;
    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IN_W  = ((DW + 7) / 8) * 8;
    localparam int OUT_W = ((DW + CNT_W + 7) / 8) * 8;

    // Flag positions in m_axis_tuser
    localparam int FLAG_UNDER = 0;
    localparam int FLAG_OVER  = 1;
    localparam int FLAG_DZ    = 2;

    // Instruction codes the block treats as no-ops
    localparam int UNUSED_OP_LO = 10;
    localparam int UNUSED_OP_HI = 15;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 750;
    localparam int MAX_SHOWN    = 10;
    localparam int LONG_HOLD    = 300;

    localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam op_t ALU_OPS [9] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX,
                                    OP_MIN, OP_NEG, OP_DUP, OP_SWAP};
    localparam op_t DRAIN_OPS [4] = '{OP_ADD, OP_SUB, OP_MAX, OP_MIN};

    typedef struct packed {
        logic [DW-1:0]    top;
        logic [CNT_W-1:0] count;
        logic             under;
        logic             over;
        logic             dz;
    } step_report_t;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;    // imm_value
    logic [FUNC_W-1:0]   s_axis_tuser  = '0;    // func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;          // top_value, stack_count
    logic [FLAG_W-1:0]   m_axis_tuser;          // underflow, overflow, div_by_zero

    // Shadow stack and the reports it predicts, oldest first
    logic [DW-1:0]  shadow_mem [DEPTH];
    int unsigned    shadow_sp = 0;
    logic           pop_empty;
    logic           push_full;
    step_report_t   pending_reports [$];

    int  error_cnt   = 0;
    int  idle_run    = 0;
    int  hold_cycles = 0;
    bit  quiet_tx    = 1'b0;
    bit  quiet_rx    = 1'b0;

    stack_machine_alu i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Pop from the shadow stack; an empty stack yields zero
    function automatic logic [DW-1:0] shadow_pop();
        if (shadow_sp == 0) begin
            pop_empty = 1'b1;
            return '0;
        end
        shadow_sp--;
        return shadow_mem[shadow_sp];
    endfunction

    // Push onto the shadow stack; drop the word when full
    function automatic void shadow_push(input logic [DW-1:0] v);
        if (shadow_sp >= DEPTH) begin
            push_full = 1'b1;
            return;
        end
        shadow_mem[shadow_sp] = v;
        shadow_sp++;
    endfunction

    // Execute one instruction on the shadow stack and build its report
    function automatic step_report_t exec_instr(input logic [FUNC_W-1:0] f,
                                                input logic [DW-1:0] imm);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        longint        num;
        longint        den;
        longint        quo;
        step_report_t  r;
        r = '0;
        pop_empty = 1'b0;
        push_full = 1'b0;
        case (f)
            OP_CONST: shadow_push(imm);
            OP_ADD: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(a + b);
            end
            OP_SUB: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(a - b);
            end
            OP_MUL: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(a * b);
            end
            OP_DIV: begin
                a = shadow_pop(); b = shadow_pop();
                if (b == '0) begin
                    r.dz = 1'b1;
                    shadow_push('0);
                end else begin
                    // 64-bit quotient keeps min / -1 defined; low bits wrap back
                    num = $signed(a);
                    den = $signed(b);
                    quo = num / den;
                    shadow_push(quo[DW-1:0]);
                end
            end
            OP_MAX: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(($signed(a) > $signed(b)) ? a : b);
            end
            OP_MIN: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(($signed(b) > $signed(a)) ? a : b);
            end
            OP_NEG: begin
                a = shadow_pop();
                shadow_push(-a);
            end
            OP_DUP: begin
                a = shadow_pop();
                shadow_push(a);
                shadow_push(a);
            end
            OP_SWAP: begin
                a = shadow_pop(); b = shadow_pop();
                shadow_push(a);
                shadow_push(b);
            end
            default: ;
        endcase
        r.top   = (shadow_sp == 0) ? '0 : shadow_mem[shadow_sp - 1];
        r.count = CNT_W'(shadow_sp);
        r.under = pop_empty;
        r.over  = push_full;
        return r;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_tx || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Immediates biased toward extremes and small divisors
    function automatic logic [DW-1:0] pick_imm();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return WORD_MIN;
            3:       return '1;
            4, 5:    return DW'($urandom_range(0, 20)) - DW'(10);
            6:       return DW'(1);
            default: return DW'($urandom);
        endcase
    endfunction

    // Keep expressions shallow; a little noise from unused codes
    function automatic logic [FUNC_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return FUNC_W'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
        if (shadow_sp > 16)
            r = r + 30;
        if ((shadow_sp < 2 && r < 70) || r < 35)
            return OP_CONST;
        return ALU_OPS[$urandom_range(0, 8)];
    endfunction

    // Offer one beat, hold it until accepted, then record its report
    task automatic send_instr(input logic [FUNC_W-1:0] f, input logic [DW-1:0] imm);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= imm;
        s_axis_tuser  <= f;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_reports.push_back(exec_instr(f, imm));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        wait (pending_reports.size() == 0);
        @(negedge aclk);
    endtask

    // Pops from an empty stack; run right after reset while the stack is empty
    task automatic test_empty_stack();
        send_instr(FUNC_W'(UNUSED_OP_LO), pick_imm());
        send_instr(OP_DUP, '0);
        send_instr(OP_ADD, '0);
        send_instr(OP_SUB, '0);
    endtask

    // Wraparound, truncation, divide by zero and min / -1
    task automatic test_arith_basics();
        send_instr(OP_CONST, WORD_MAX);
        send_instr(OP_CONST, DW'(1));
        send_instr(OP_ADD,   DW'($urandom));
        send_instr(OP_CONST, '1);
        send_instr(OP_SWAP,  '0);
        send_instr(OP_DIV,   '0);
        send_instr(OP_NEG,   '0);
        send_instr(OP_CONST, '0);
        send_instr(OP_SWAP,  '0);
        send_instr(OP_DIV,   '0);
        send_instr(OP_CONST, DW'(2));
        send_instr(OP_CONST, -DW'(7));
        send_instr(OP_DIV,   '0);
        send_instr(OP_CONST, DW'(6));
        send_instr(OP_MUL,   '0);
        send_instr(OP_CONST, DW'(5));
        send_instr(OP_MAX,   '0);
        send_instr(OP_CONST, WORD_MIN);
        send_instr(OP_MIN,   '0);
    endtask

    task automatic test_unused_codes();
        send_instr(FUNC_W'(UNUSED_OP_LO), '1);
        send_instr(FUNC_W'(UNUSED_OP_HI), WORD_MIN);
    endtask

    // Fill to the top, push past it, then drain back down
    task automatic test_full_stack();
        while (shadow_sp < DEPTH)
            send_instr(OP_CONST, pick_imm());
        send_instr(OP_CONST, pick_imm());
        send_instr(OP_DUP,   '0);
        send_instr(OP_SWAP,  '0);
        send_instr(OP_MUL,   '0);
        send_instr(OP_DUP,   '0);
        send_instr(OP_NEG,   '0);
        send_instr(OP_CONST, pick_imm());
        while (shadow_sp > 4) begin
            if ($urandom_range(0, 9) == 0)
                send_instr(($urandom_range(0, 1) == 0) ? OP_MUL : OP_DIV, '0);
            else
                send_instr(DRAIN_OPS[$urandom_range(0, 3)], pick_imm());
        end
    endtask

    // Stall the result side for a long stretch while beats keep coming
    task automatic test_backpressure();
        quiet_tx = 1'b1;
        hold_cycles = LONG_HOLD;
        repeat (20)
            send_instr(pick_op(), pick_imm());
        quiet_tx = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // one stretch with no idling on either side
            quiet_tx = (i >= 300 && i < 400);
            quiet_rx = quiet_tx;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            send_instr(pick_op(), pick_imm());
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // Result-side ready: random stalls, or a long hold on request
    initial begin : rx_ready
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                stall_left = hold_cycles;
                hold_cycles = 0;
            end else if (stall_left == 0 && !quiet_rx) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    stall_left = $urandom_range(1, 3);
                else if (r < 19)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest pending report
    always @(posedge aclk) begin : check_results
        step_report_t want;
        step_report_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.top   = m_axis_tdata[DW-1:0];
            got.count = m_axis_tdata[DW +: CNT_W];
            got.under = m_axis_tuser[FLAG_UNDER];
            got.over  = m_axis_tuser[FLAG_OVER];
            got.dz    = m_axis_tuser[FLAG_DZ];
            if (pending_reports.size() == 0) begin
                error_cnt++;
                if (error_cnt <= MAX_SHOWN)
                    $display("%0t: result beat with nothing pending: top=%h count=%0d",
                             $realtime, got.top, got.count);
            end else begin
                want = pending_reports.pop_front();
                if (got.top !== want.top || got.count !== want.count ||
                    got.under !== want.under || got.over !== want.over ||
                    got.dz !== want.dz) begin
                    error_cnt++;
                    if (error_cnt <= MAX_SHOWN)
                        $display("%0t: mismatch exp top=%h cnt=%0d uf=%b of=%b dz=%b, %s%h %s%0d uf=%b of=%b dz=%b",
                                 $realtime, want.top, want.count, want.under, want.over,
                                 want.dz, "got top=", got.top, "cnt=", got.count,
                                 got.under, got.over, got.dz);
                end
            end
        end
    end

    // End the run when no beat moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin : main_seq
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_stack();
        test_arith_basics();
        test_unused_codes();
        test_full_stack();
        test_backpressure();
        test_random();

        s_axis_tvalid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (60) @(posedge aclk);

        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
